@@ sv/miq_pkg.sv @@
// Shared constants, types and ring-pointer helpers for the middle insert queue.
package miq_pkg;

  // Queue sizing
  localparam int CAPACITY   = 1024;
  localparam int ID_WIDTH   = 32;
  localparam int HALF_DEPTH = (CAPACITY + 1) / 2;

  // Port and storage widths
  localparam int VALUE_W = 32;
  localparam int STORE_W = (ID_WIDTH < VALUE_W) ? ID_WIDTH : VALUE_W;
  localparam int PTR_W   = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
  localparam int CNT_W   = $clog2(HALF_DEPTH + 1);
  localparam int TOT_W   = $clog2(CAPACITY + 2);

  // Request operation codes
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // One ring memory access for a cycle
  typedef struct packed {
    logic               we;
    logic [PTR_W-1:0]   waddr;
    logic [STORE_W-1:0] wdata;
    logic [PTR_W-1:0]   raddr;
  } ram_req_t;

  // ptr + cnt modulo the ring depth (ptr < HALF_DEPTH, cnt <= HALF_DEPTH)
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] ptr,
                                                 input logic [CNT_W-1:0] cnt);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(ptr) + (CNT_W + 1)'(cnt);
    if (sum >= (CNT_W + 1)'(HALF_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(HALF_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] ptr);
    return ring_add(ptr, CNT_W'(1));
  endfunction

  function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] ptr);
    return ring_add(ptr, CNT_W'(HALF_DEPTH - 1));
  endfunction

endpackage

@@ sv/middle_insert_queue.sv @@
// Top level: queue with middle insertion, front and back ring memories plus sequencer.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+-----------------------------
//  request | in_valid_i  | in_ready_o  | operation_i, value_i
//  result  | out_valid_o | out_ready_i | popped_value_o, status_o
//
// Append, insert, unused codes and failed requests complete at accept; a pop that
// finds an entry, and an append that must move the back head to the front,
// also pass through a finish step that waits on the registered read of a ring memory.
// One request is in flight at a time.
// Reset clears state, pointers, counts and the result register; ring contents are never cleared.
// A pending result does not block the next request if out_ready_i is high.
module middle_insert_queue
  import miq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [VALUE_W-1:0] popped_value_o,
  output logic [1:0]         status_o
);

  ram_req_t           front_req;
  ram_req_t           back_req;
  logic [STORE_W-1:0] front_rdata;
  logic [STORE_W-1:0] back_rdata;

  // First ceil(L/2) entries
  miq_ram #(
    .DEPTH (HALF_DEPTH),
    .WIDTH (STORE_W),
    .ADDR_W(PTR_W)
  ) u_front_ram (
    .clk_i  (clk_i),
    .we_i   (front_req.we),
    .waddr_i(front_req.waddr),
    .wdata_i(front_req.wdata),
    .raddr_i(front_req.raddr),
    .rdata_o(front_rdata)
  );

  // Remaining entries
  miq_ram #(
    .DEPTH (HALF_DEPTH),
    .WIDTH (STORE_W),
    .ADDR_W(PTR_W)
  ) u_back_ram (
    .clk_i  (clk_i),
    .we_i   (back_req.we),
    .waddr_i(back_req.waddr),
    .wdata_i(back_req.wdata),
    .raddr_i(back_req.raddr),
    .rdata_o(back_rdata)
  );

  // Sequencer
  miq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .popped_value_o(popped_value_o),
    .status_o      (status_o),
    .front_req_o   (front_req),
    .front_rdata_i (front_rdata),
    .back_req_o    (back_req),
    .back_rdata_i  (back_rdata)
  );

endmodule

@@ sv/miq_ram.sv @@
// Simple dual-port ring memory with one registered read port.
module miq_ram #(
  parameter int DEPTH  = 512,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ sv/miq_ctrl.sv @@
// Sequencer: ring pointers, counts, rebalancing moves and the result register.
module miq_ctrl
  import miq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [VALUE_W-1:0] popped_value_o,
  output logic [1:0]         status_o,
  output ram_req_t           front_req_o,
  input  logic [STORE_W-1:0] front_rdata_i,
  output ram_req_t           back_req_o,
  input  logic [STORE_W-1:0] back_rdata_i
);

  typedef enum logic {
    S_IDLE,
    S_FINISH
  } state_e;

  state_e             state_q, state_d;
  logic [PTR_W-1:0]   front_head_q, front_head_d;
  logic [CNT_W-1:0]   front_count_q, front_count_d;
  logic [PTR_W-1:0]   back_head_q, back_head_d;
  logic [CNT_W-1:0]   back_count_q, back_count_d;
  logic               move_q, move_d;
  logic [PTR_W-1:0]   move_addr_q, move_addr_d;
  logic               pop_q, pop_d;
  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] out_value_q, out_value_d;
  status_e            out_status_q, out_status_d;

  logic               accept;
  logic [TOT_W-1:0]   total;
  logic               full;
  logic               even;
  logic [PTR_W-1:0]   front_tail;
  logic [PTR_W-1:0]   back_tail;
  logic [STORE_W-1:0] wr_value;

  assign in_ready_o     = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept         = in_valid_i && in_ready_o;
  assign out_valid_o    = out_valid_q;
  assign popped_value_o = out_value_q;
  assign status_o       = out_status_q;

  // Occupancy and ring positions
  assign total      = TOT_W'(front_count_q) + TOT_W'(back_count_q);
  assign full       = (total >= TOT_W'(CAPACITY)) || (back_count_q >= CNT_W'(HALF_DEPTH));
  assign even       = (front_count_q == back_count_q);
  assign front_tail = ring_add(front_head_q, front_count_q);
  assign back_tail  = ring_add(back_head_q, back_count_q);
  assign wr_value   = value_i[STORE_W-1:0];

  // Next state: all pointer updates land at accept, the move write follows
  always_comb begin
    state_d       = state_q;
    front_head_d  = front_head_q;
    front_count_d = front_count_q;
    back_head_d   = back_head_q;
    back_count_d  = back_count_q;
    move_d        = 1'b0;
    move_addr_d   = move_addr_q;
    pop_d         = 1'b0;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_value_d   = out_value_q;
    out_status_d  = out_status_q;

    front_req_o.we    = 1'b0;
    front_req_o.waddr = front_tail;
    front_req_o.wdata = wr_value;
    front_req_o.raddr = front_head_q;
    back_req_o.we     = 1'b0;
    back_req_o.waddr  = back_tail;
    back_req_o.wdata  = wr_value;
    back_req_o.raddr  = back_head_q;

    if (state_q == S_FINISH) begin
      // back head moves to the front tail; popped head is on the read port
      front_req_o.we    = move_q;
      front_req_o.waddr = move_addr_q;
      front_req_o.wdata = back_rdata_i;
      if (pop_q) begin
        out_valid_d  = 1'b1;
        out_value_d  = VALUE_W'(front_rdata_i);
        out_status_d = ST_OK;
      end
      state_d = S_IDLE;
    end else if (accept) begin
      unique case (operation_i)
        OP_APPEND, OP_INSERT: begin
          if (full) begin
            out_valid_d  = 1'b1;
            out_value_d  = '0;
            out_status_d = ST_FULL;
          end else if (even && (operation_i == OP_INSERT || back_count_q == '0)) begin
            // new value lands straight at the front tail
            front_req_o.we = 1'b1;
            front_count_d  = front_count_q + CNT_W'(1);
          end else if (operation_i == OP_APPEND && even) begin
            // push at back tail, move back head to front
            back_req_o.we = 1'b1;
            back_head_d   = ring_inc(back_head_q);
            front_count_d = front_count_q + CNT_W'(1);
            move_d        = 1'b1;
            move_addr_d   = front_tail;
            state_d       = S_FINISH;
          end else if (operation_i == OP_APPEND) begin
            back_req_o.we = 1'b1;
            back_count_d  = back_count_q + CNT_W'(1);
          end else begin
            back_req_o.we    = 1'b1;
            back_req_o.waddr = ring_dec(back_head_q);
            back_head_d      = ring_dec(back_head_q);
            back_count_d     = back_count_q + CNT_W'(1);
          end
        end
        OP_POP: begin
          if (front_count_q == '0) begin
            out_valid_d  = 1'b1;
            out_value_d  = '0;
            out_status_d = ST_EMPTY;
          end else begin
            front_head_d = ring_inc(front_head_q);
            pop_d        = 1'b1;
            state_d      = S_FINISH;
            if (even) begin
              // refill front from back head; front count is unchanged
              move_d       = 1'b1;
              move_addr_d  = front_tail;
              back_head_d  = ring_inc(back_head_q);
              back_count_d = back_count_q - CNT_W'(1);
            end else begin
              front_count_d = front_count_q - CNT_W'(1);
            end
          end
        end
        default: begin
          // unused operation code: no effect
        end
      endcase
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      front_head_q  <= '0;
      front_count_q <= '0;
      back_head_q   <= '0;
      back_count_q  <= '0;
      move_q        <= 1'b0;
      move_addr_q   <= '0;
      pop_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      out_value_q   <= '0;
      out_status_q  <= ST_OK;
    end else begin
      state_q       <= state_d;
      front_head_q  <= front_head_d;
      front_count_q <= front_count_d;
      back_head_q   <= back_head_d;
      back_count_q  <= back_count_d;
      move_q        <= move_d;
      move_addr_q   <= move_addr_d;
      pop_q         <= pop_d;
      out_valid_q   <= out_valid_d;
      out_value_q   <= out_value_d;
      out_status_q  <= out_status_d;
    end
  end

`ifndef ASSERT_OFF
  // Front always holds ceil(L/2) entries
  a_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_count_q == back_count_q) || (front_count_q == back_count_q + CNT_W'(1)))
    else $error("front/back split broken");

  // Occupancy never exceeds capacity
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total <= TOT_W'(CAPACITY))
    else $error("queue over capacity");

  // Ring heads stay inside the ring
  a_heads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(front_head_q) < HALF_DEPTH) && (32'(back_head_q) < HALF_DEPTH))
    else $error("ring head out of range");

  // Finish step returns to idle in the next cycle
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FINISH |=> state_q == S_IDLE)
    else $error("finish step stuck");

  // Pop result slot is free when the popped value arrives
  a_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FINISH && pop_q |-> !out_valid_q)
    else $error("pop result would overwrite pending result");
`endif

endmodule

@@ bench/tb_middle_insert_queue.sv @@
// Self-checking testbench for the middle insert queue: directed, random and stall tests.
`timescale 1ns / 1ps

module tb_middle_insert_queue;
  import miq_pkg::*;

  // Op code with no meaning; the block must ignore it
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SINK_HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES       = 20;

  typedef struct {
    logic [VALUE_W-1:0] value;
    status_e            status;
  } queue_reply_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         operation_i = OP_APPEND;
  logic [VALUE_W-1:0] value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [VALUE_W-1:0] popped_value_o;
  logic [1:0]         status_o;

  middle_insert_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .popped_value_o (popped_value_o),
    .status_o       (status_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the two rings
  logic [STORE_W-1:0] front_mem [HALF_DEPTH];
  logic [STORE_W-1:0] back_mem  [HALF_DEPTH];
  int front_first = 0;
  int front_held  = 0;
  int back_first  = 0;
  int back_held   = 0;

  queue_reply_t awaited_replies [$];

  // Run statistics
  int err_count    = 0;
  int n_append     = 0;
  int n_insert     = 0;
  int n_pop        = 0;
  int n_ignored    = 0;
  int n_checked    = 0;
  int n_full_drop  = 0;
  int n_empty_pop  = 0;
  int peak_depth   = 0;

  // Idle control shared by both sides
  bit idle_on          = 1'b1;
  int sink_hold_left   = 0;
  int sink_stall_left  = 0;

  // Index arithmetic modulo the ring depth
  function automatic int ring_step(int a, int b);
    int s;
    s = a + b;
    if (s >= HALF_DEPTH) s -= HALF_DEPTH;
    return s;
  endfunction

  // Move one entry so the front half holds ceil(L/2)
  function automatic void even_out_halves();
    int                 target;
    logic [STORE_W-1:0] v;
    target = (front_held + back_held + 1) / 2;
    if (front_held < target && back_held > 0) begin
      v = back_mem[back_first];
      back_first = ring_step(back_first, 1);
      back_held--;
      front_mem[ring_step(front_first, front_held)] = v;
      front_held++;
    end else if (front_held > target && front_held > 0) begin
      v = front_mem[ring_step(front_first, front_held - 1)];
      front_held--;
      back_first = ring_step(back_first, HALF_DEPTH - 1);
      back_mem[back_first] = v;
      back_held++;
    end
  endfunction

  // Update the shadow queue for one accepted request, queue any reply
  function automatic void apply_queue_op(logic [1:0] op, logic [VALUE_W-1:0] val);
    queue_reply_t       r;
    logic [STORE_W-1:0] v;
    v = val[STORE_W-1:0];
    case (op)
      OP_APPEND, OP_INSERT: begin
        if (front_held + back_held >= CAPACITY || back_held >= HALF_DEPTH) begin
          r.value  = '0;
          r.status = ST_FULL;
          awaited_replies.push_back(r);
          n_full_drop++;
        end else begin
          if (op == OP_APPEND) begin
            back_mem[ring_step(back_first, back_held)] = v;
          end else begin
            back_first = ring_step(back_first, HALF_DEPTH - 1);
            back_mem[back_first] = v;
          end
          back_held++;
          even_out_halves();
        end
      end
      OP_POP: begin
        if (front_held == 0) begin
          r.value  = '0;
          r.status = ST_EMPTY;
          n_empty_pop++;
        end else begin
          r.value  = VALUE_W'(front_mem[front_first]);
          r.status = ST_OK;
          front_first = ring_step(front_first, 1);
          front_held--;
          even_out_halves();
        end
        awaited_replies.push_back(r);
      end
      default: ;
    endcase
    if (front_held + back_held > peak_depth) peak_depth = front_held + back_held;
  endfunction

  task automatic note_mismatch(string what, logic [VALUE_W-1:0] want,
                               logic [VALUE_W-1:0] got);
    $display("[%0t] %s: expected %h, got %h", $time, what, want, got);
    err_count++;
  endtask

  // Request and result monitor
  always @(posedge clk_i) begin
    queue_reply_t r;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_replies.size() == 0) begin
          note_mismatch("result with nothing outstanding", '0, popped_value_o);
        end else begin
          r = awaited_replies.pop_front();
          n_checked++;
          if (status_o !== r.status)
            note_mismatch("status", VALUE_W'(r.status), VALUE_W'(status_o));
          if (popped_value_o !== r.value)
            note_mismatch("popped value", r.value, popped_value_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        case (operation_i)
          OP_APPEND: n_append++;
          OP_INSERT: n_insert++;
          OP_POP:    n_pop++;
          default:   n_ignored++;
        endcase
        apply_queue_op(operation_i, value_i);
      end
    end
  end

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result receiver: random stalls plus an optional long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (sink_hold_left > 0) begin
      out_ready_i <= 1'b0;
      sink_hold_left--;
    end else if (sink_stall_left > 0) begin
      out_ready_i <= 1'b0;
      sink_stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      if (idle_on && $urandom_range(0, 99) < 30) sink_stall_left = pick_gap();
    end
  end

  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    if (r < 15) return VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
    return VALUE_W'($urandom());
  endfunction

  function automatic logic [1:0] pick_push_op();
    return ($urandom_range(0, 1) == 0) ? OP_APPEND : OP_INSERT;
  endfunction

  // Drop valid; used before any wait that is not a new request
  task automatic sender_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Offer one request after a random gap and hold it until accepted
  task automatic send_req(logic [1:0] op, logic [VALUE_W-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    operation_i <= op;
    value_i     <= val;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    sender_idle();
    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Extremes, every op code, empty pops and middle inserts at odd and even length
  task automatic test_directed();
    send_req(OP_POP, '1);
    send_req(OP_UNUSED, '1);
    send_req(OP_APPEND, '0);
    send_req(OP_APPEND, '1);
    send_req(OP_INSERT, 32'hA5A5_A5A5);
    send_req(OP_INSERT, 32'h5A5A_5A5A);
    send_req(OP_APPEND, 32'h0000_0001);
    send_req(OP_INSERT, 32'h8000_0000);
    send_req(OP_UNUSED, 32'h1234_5678);
    repeat (6) send_req(OP_POP, 32'hFFFF_0000);
    send_req(OP_POP, '0);
    send_req(OP_INSERT, 32'hDEAD_BEEF);
    send_req(OP_POP, '0);
    send_req(OP_APPEND, 32'h0000_0007);
    send_req(OP_APPEND, 32'h0000_0008);
    send_req(OP_INSERT, 32'h0000_0009);
    repeat (3) send_req(OP_POP, '0);
  endtask

  task automatic test_random_mix(int count);
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 35) send_req(OP_APPEND, pick_value());
      else if (r < 60) send_req(OP_INSERT, pick_value());
      else if (r < 95) send_req(OP_POP, pick_value());
      else send_req(OP_UNUSED, pick_value());
    end
  endtask

  // Receiver stops for a long stretch while requests keep coming
  task automatic test_backpressure();
    repeat (10) send_req(pick_push_op(), pick_value());
    sink_hold_left = SINK_HOLD_CYCLES;
    repeat (30) send_req(($urandom_range(0, 2) == 0) ? pick_push_op() : OP_POP,
                         pick_value());
  endtask

  // Sender stops until every outstanding result is back
  task automatic test_sender_pause();
    wait_drained();
    repeat (20) send_req(($urandom_range(0, 1) == 0) ? pick_push_op() : OP_POP,
                         pick_value());
  endtask

  // Fill to capacity without idling, hit the full case, churn near the top
  task automatic test_fill_to_full();
    int room;
    wait_drained();
    room    = CAPACITY - (front_held + back_held);
    idle_on = 1'b0;
    repeat (room) send_req(pick_push_op(), pick_value());
    idle_on = 1'b1;
    send_req(OP_APPEND, '1);
    send_req(OP_INSERT, '0);
    repeat (4) send_req(pick_push_op(), pick_value());
    repeat (30) begin
      send_req(OP_POP, '0);
      send_req(pick_push_op(), pick_value());
    end
  endtask

  task automatic test_drain(int count);
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) send_req(pick_push_op(), pick_value());
      else send_req(OP_POP, pick_value());
    end
  endtask

  // Safety net against a hung handshake
  initial begin
    #(20_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_mix(300);
    test_backpressure();
    test_sender_pause();
    test_fill_to_full();
    test_drain(350);
    sender_idle();
    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Requests: %0d appends, %0d inserts, %0d pops, %0d ignored codes.",
             n_append, n_insert, n_pop, n_ignored);
    $display("%0d results checked, %0d full drops, %0d empty pops, peak depth %0d/%0d.",
             n_checked, n_full_drop, n_empty_pop, peak_depth, CAPACITY);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/miq_pkg.sv
sv/miq_ram.sv
sv/miq_ctrl.sv
sv/middle_insert_queue.sv
bench/tb_middle_insert_queue.sv
